/* rtl/fexp_pkg.sv */
// Shared types, constants and a helper function for the fast exponential core.
// No dependencies; imported by the FMA unit, the top level and the testbench.
`default_nettype none

package fexp_pkg;

    // Number of register stages in one fused multiply-add unit.
    localparam int FMA_STAGES = 5;

    // Single-precision constants of the approximation.
    localparam logic [31:0] K_L2E  = 32'h3FB8AA3B;
    localparam logic [31:0] K_CVT  = 32'h4B400000;
    localparam logic [31:0] K_C0   = 32'h3E7426B7;
    localparam logic [31:0] K_C1   = 32'h3F34152B;
    localparam logic [31:0] K_C2   = 32'h3F800E85;
    localparam logic [31:0] K_ONE  = 32'h3F800000;
    localparam logic [31:0] K_SIGN = 32'h80000000;
    localparam logic [31:0] K_DNAN = 32'hFFC00000;

    // Signed exponent wide enough for every intermediate scale.
    typedef logic signed [11:0] t_exp;

    // Data that travels beside the arithmetic units.
    typedef struct packed {
        logic        spec;
        logic [31:0] spec_y;
        logic [31:0] t;
        logic [8:0]  ival;
        logic [31:0] f;
    } t_side;

    // Position of the highest set bit plus one; zero for a zero word.
    function automatic logic [6:0] bit_len64(input logic [63:0] m);
        logic [6:0] n;
        n = 7'd0;
        for (int i = 0; i < 64; i++) begin
            if (m[i]) begin
                n = 7'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* rtl/fexp_fma.sv */
// Pipelined single-precision fused multiply-add, a*b + c with one rounding.
// Depends on fexp_pkg; each stage register advances on its own enable bit.
`default_nettype none

module fexp_fma import fexp_pkg::*; (
    input  logic                  i_clk,
    input  logic [FMA_STAGES-1:0] i_en,
    input  logic [31:0]           i_a,
    input  logic [31:0]           i_b,
    input  logic [31:0]           i_c,
    output logic [31:0]           o_res
);

    // Stage 1: unpack the operands and form the exact product.
    logic [47:0] r1_mp;
    t_exp        r1_ep;
    logic [23:0] r1_mc;
    t_exp        r1_ec;
    logic        r1_sp;
    logic        r1_sc;
    logic [31:0] r1_c;
    logic [47:0] n1_mp;
    t_exp        n1_ep;
    logic [23:0] n1_mc;
    t_exp        n1_ec;

    always_comb begin
        logic [23:0] ma;
        logic [23:0] mb;
        t_exp        ea;
        t_exp        eb;
        ma = {(i_a[30:23] != 8'd0), i_a[22:0]};
        mb = {(i_b[30:23] != 8'd0), i_b[22:0]};
        n1_mc = {(i_c[30:23] != 8'd0), i_c[22:0]};
        ea = (i_a[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, i_a[30:23]}) - 12'sd150;
        eb = (i_b[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, i_b[30:23]}) - 12'sd150;
        n1_ec = (i_c[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, i_c[30:23]}) - 12'sd150;
        n1_mp = ma * mb;
        n1_ep = ea + eb;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_mp <= n1_mp;
            r1_ep <= n1_ep;
            r1_mc <= n1_mc;
            r1_ec <= n1_ec;
            r1_sp <= i_a[31] ^ i_b[31];
            r1_sc <= i_c[31];
            r1_c  <= i_c;
        end
    end

    // Stage 2: normalize product and addend to a common width, then order them.
    logic [63:0] r2_big;
    logic [63:0] r2_sml;
    logic        r2_sbig;
    logic        r2_ssml;
    t_exp        r2_ebig;
    t_exp        r2_d;
    logic        r2_pz;
    logic        r2_cz;
    logic        r2_sp;
    logic        r2_sc;
    logic [31:0] r2_c;
    logic [63:0] n2_big;
    logic [63:0] n2_sml;
    logic        n2_sbig;
    logic        n2_ssml;
    t_exp        n2_ebig;
    t_exp        n2_d;

    always_comb begin
        logic [6:0]  sh_p;
        logic [6:0]  sh_c;
        logic [63:0] mpn;
        logic [63:0] mcn;
        t_exp        epn;
        t_exp        ecn;
        sh_p = 7'd62 - bit_len64({16'd0, r1_mp});
        sh_c = 7'd62 - bit_len64({40'd0, r1_mc});
        mpn = {16'd0, r1_mp} << sh_p[5:0];
        mcn = {40'd0, r1_mc} << sh_c[5:0];
        epn = r1_ep - $signed({5'd0, sh_p});
        ecn = r1_ec - $signed({5'd0, sh_c});
        if (r1_mc == 24'd0 || epn >= ecn) begin
            n2_big  = mpn;
            n2_sbig = r1_sp;
            n2_ebig = epn;
            n2_ssml = r1_sc;
            n2_sml  = (r1_mc == 24'd0) ? 64'd0 : mcn;
            n2_d    = (r1_mc == 24'd0) ? 12'sd0 : epn - ecn;
        end else begin
            n2_big  = mcn;
            n2_sbig = r1_sc;
            n2_ebig = ecn;
            n2_ssml = r1_sp;
            n2_sml  = mpn;
            n2_d    = ecn - epn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_big  <= n2_big;
            r2_sml  <= n2_sml;
            r2_sbig <= n2_sbig;
            r2_ssml <= n2_ssml;
            r2_ebig <= n2_ebig;
            r2_d    <= n2_d;
            r2_pz   <= (r1_mp == 48'd0);
            r2_cz   <= (r1_mc == 24'd0);
            r2_sp   <= r1_sp;
            r2_sc   <= r1_sc;
            r2_c    <= r1_c;
        end
    end

    // Stage 3: align the smaller term with a sticky bit and add or subtract.
    logic [63:0] r3_m;
    logic        r3_sign;
    t_exp        r3_ebig;
    logic        r3_pz;
    logic        r3_cz;
    logic        r3_sp;
    logic        r3_sc;
    logic [31:0] r3_c;
    logic [63:0] n3_m;
    logic        n3_sign;

    always_comb begin
        logic [63:0] sa;
        logic        sticky;
        sticky = |(r2_sml & ((64'd1 << r2_d[5:0]) - 64'd1));
        if (r2_d >= 12'sd63) begin
            sa = 64'd1;
        end else if (r2_d > 12'sd0) begin
            sa = (r2_sml >> r2_d[5:0]) | {63'd0, sticky};
        end else begin
            sa = r2_sml;
        end
        if (r2_sbig == r2_ssml) begin
            n3_m    = r2_big + sa;
            n3_sign = r2_sbig;
        end else if (r2_big >= sa) begin
            n3_m    = r2_big - sa;
            n3_sign = r2_sbig;
        end else begin
            n3_m    = sa - r2_big;
            n3_sign = r2_ssml;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_m    <= n3_m;
            r3_sign <= n3_sign;
            r3_ebig <= r2_ebig;
            r3_pz   <= r2_pz;
            r3_cz   <= r2_cz;
            r3_sp   <= r2_sp;
            r3_sc   <= r2_sc;
            r3_c    <= r2_c;
        end
    end

    // Stage 4: find the rounding position, limited at the subnormal boundary.
    logic [63:0] r4_m;
    t_exp        r4_s;
    t_exp        r4_e2;
    logic        r4_sign;
    logic        r4_pz;
    logic        r4_cz;
    logic        r4_sp;
    logic        r4_sc;
    logic [31:0] r4_c;
    t_exp        n4_s;
    t_exp        n4_e2;

    always_comb begin
        n4_s  = $signed({5'd0, bit_len64(r3_m)}) - 12'sd24;
        n4_e2 = r3_ebig + n4_s;
        if (n4_e2 < -12'sd149) begin
            n4_s  = n4_s + (-12'sd149 - n4_e2);
            n4_e2 = -12'sd149;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_m    <= r3_m;
            r4_s    <= n4_s;
            r4_e2   <= n4_e2;
            r4_sign <= r3_sign;
            r4_pz   <= r3_pz;
            r4_cz   <= r3_cz;
            r4_sp   <= r3_sp;
            r4_sc   <= r3_sc;
            r4_c    <= r3_c;
        end
    end

    // Stage 5: shift, round to nearest even, pack, and apply zero cases.
    logic [31:0] r5_res;
    logic [31:0] n5_res;

    always_comb begin
        logic [63:0] q;
        logic        half;
        logic        rest;
        logic [5:0]  sh;
        t_exp        e2;
        t_exp        biased;
        t_exp        neg_s;
        logic [31:0] packed_res;
        e2    = r4_e2;
        half  = 1'b0;
        rest  = 1'b0;
        sh    = r4_s[5:0];
        neg_s = -r4_s;
        if (r4_s <= 12'sd0) begin
            q = r4_m << neg_s[5:0];
        end else if (r4_s >= 12'sd64) begin
            q = 64'd0;
        end else begin
            q    = r4_m >> sh;
            half = r4_m[sh - 6'd1];
            rest = |(r4_m & ((64'd1 << (sh - 6'd1)) - 64'd1));
        end
        if (half && (rest || q[0])) begin
            q = q + 64'd1;
            if (q == 64'h0000_0000_0100_0000) begin
                q  = q >> 1;
                e2 = e2 + 12'sd1;
            end
        end
        biased = e2 + 12'sd150;
        if (q[23]) begin
            if (biased >= 12'sd255) begin
                packed_res = {r4_sign, 8'hFF, 23'd0};
            end else begin
                packed_res = {r4_sign, biased[7:0], q[22:0]};
            end
        end else begin
            packed_res = {r4_sign, 8'd0, q[22:0]};
        end
        if (r4_pz) begin
            if (r4_cz) begin
                n5_res = (r4_sp == r4_sc) ? {r4_sp, 31'd0} : 32'd0;
            end else begin
                n5_res = r4_c;
            end
        end else if (r4_m == 64'd0) begin
            n5_res = 32'd0;
        end else begin
            n5_res = packed_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r5_res <= n5_res;
        end
    end

    assign o_res = r5_res;

endmodule

`default_nettype wire

/* rtl/fast_exp_quadratic_float_core.sv */
// Top level of the fast single-precision exponential: six chained FMA units.
// Depends on fexp_pkg and fexp_fma.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-----------------
//  input   | in        | i_valid / o_ready   | i_x_bits [31:0]
//  output  | out       | o_valid / i_ready   | o_y_bits [31:0]
//
// A request passes 31 register stages: six FMA units of five stages each plus the
// output register. One request enters per cycle and one result leaves per cycle while
// no stall from i_ready holds them back; every stage is pipelined.
// Reset clears every valid bit; payload registers are not reset.
// A stall holds a stage only while it is occupied, so bubbles close up behind it.
`default_nettype none

module fast_exp_quadratic_float_core import fexp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_x_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_y_bits
);

    localparam int N_OPS  = 6;
    localparam int N_PIPE = N_OPS * FMA_STAGES;

    logic [N_PIPE:0] r_v;
    logic [N_PIPE:0] en;
    t_side           r_side [N_PIPE];
    t_side           n_side [N_PIPE];
    logic [31:0]     w_res  [N_OPS];
    logic [31:0]     op_a   [N_OPS];
    logic [31:0]     op_b   [N_OPS];
    logic [31:0]     op_c   [N_OPS];
    logic [31:0]     r_y;
    logic [31:0]     n_y;

    // Float to int32 with nearest-even rounding; out of range gives the sign pattern.
    function automatic logic [31:0] to_int(input logic [31:0] t);
        logic [7:0]  bexp;
        logic [31:0] sig;
        logic [31:0] v;
        logic [31:0] q;
        logic [4:0]  s;
        logic        half;
        logic        rest;
        bexp = t[30:23];
        sig  = {8'd0, 1'b1, t[22:0]};
        v    = 32'd0;
        if (bexp >= 8'd158) begin
            return K_SIGN;
        end
        if (bexp < 8'd126) begin
            return 32'd0;
        end
        if (bexp >= 8'd150) begin
            v = sig << (bexp - 8'd150);
        end else begin
            s    = 5'(8'd150 - bexp);
            q    = sig >> s;
            half = sig[s - 5'd1];
            rest = |(sig & ((32'd1 << (s - 5'd1)) - 32'd1));
            if (half && (rest || q[0])) begin
                q = q + 32'd1;
            end
            v = q;
        end
        if (t[31]) begin
            v = 32'd0 - v;
        end
        return v;
    endfunction

    // Stage enables: a stage moves when it is empty or the next one moves.
    always_comb begin
        en[N_PIPE] = !r_v[N_PIPE] || i_ready;
        for (int j = N_PIPE - 1; j >= 0; j--) begin
            en[j] = !r_v[j] || en[j + 1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[N_PIPE];
    assign o_y_bits = r_y;

    // Valid bits travel with their data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int j = 1; j <= N_PIPE; j++) begin
                if (en[j]) begin
                    r_v[j] <= r_v[j - 1];
                end
            end
        end
    end

    // Operand selection for each FMA unit.
    always_comb begin
        op_a[0] = i_x_bits;   op_b[0] = K_L2E;    op_c[0] = K_SIGN;
        op_a[1] = w_res[0];   op_b[1] = K_ONE;    op_c[1] = K_CVT;
        op_a[2] = w_res[1];   op_b[2] = K_ONE;    op_c[2] = K_CVT ^ K_SIGN;
        op_a[3] = r_side[3 * FMA_STAGES - 1].t;
        op_b[3] = K_ONE;
        op_c[3] = w_res[2] ^ K_SIGN;
        op_a[4] = K_C0;       op_b[4] = w_res[3]; op_c[4] = K_C1;
        op_a[5] = w_res[4];
        op_b[5] = r_side[5 * FMA_STAGES - 1].f;
        op_c[5] = K_C2;
    end

    for (genvar k = 0; k < N_OPS; k++) begin : g_op
        fexp_fma u_fma (
            .i_clk (i_clk),
            .i_en  (en[k * FMA_STAGES +: FMA_STAGES]),
            .i_a   (op_a[k]),
            .i_b   (op_b[k]),
            .i_c   (op_c[k]),
            .o_res (w_res[k])
        );
    end

    // Side data: special-case result, t, integer part and fraction.
    always_comb begin
        for (int j = 0; j < N_PIPE; j++) begin
            if (j == 0) begin
                n_side[j]        = '0;
                n_side[j].spec   = (i_x_bits[30:23] == 8'hFF);
                n_side[j].spec_y = (i_x_bits[22:0] != 23'd0) ?
                                   (i_x_bits | 32'h0040_0000) : K_DNAN;
            end else begin
                n_side[j] = r_side[j - 1];
            end
            if (j == FMA_STAGES) begin
                n_side[j].t    = w_res[0];
                n_side[j].ival = 9'(to_int(w_res[0]));
                if (!r_side[j - 1].spec && w_res[0][30:0] == 31'h7F80_0000) begin
                    n_side[j].spec   = 1'b1;
                    n_side[j].spec_y = K_DNAN;
                end
            end
            if (j == 4 * FMA_STAGES) begin
                n_side[j].f = w_res[3];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < N_PIPE; j++) begin
            if (en[j]) begin
                r_side[j] <= n_side[j];
            end
        end
    end

    // Output stage: special-case result, or shifted integer part plus polynomial bits.
    always_comb begin
        if (r_side[N_PIPE - 1].spec) begin
            n_y = r_side[N_PIPE - 1].spec_y;
        end else begin
            n_y = {r_side[N_PIPE - 1].ival, 23'd0} + w_res[N_OPS - 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[N_PIPE]) begin
            r_y <= n_y;
        end
    end

endmodule

`default_nettype wire

/* rtl/fexp_checker.sv */
// Port-level checks for the fast exponential core, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module fexp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_y_bits
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result request dropped while stalled");

    // A stalled result keeps its value.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_y_bits))
        else $error("result changed while stalled");

    // An empty or draining output never blocks the input side.
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input blocked although the output moves");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("pipeline not empty after reset");

endmodule

bind fast_exp_quadratic_float_core fexp_checker u_fexp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_y_bits (o_y_bits)
);

`default_nettype wire

/* tb/fast_exp_quadratic_float_core_tb.sv */
// Self-checking testbench for the fast single-precision exponential core.
// Depends on fexp_pkg (constants) and the fast_exp_quadratic_float_core RTL.
// A bit-exact integer predictor computes each expected result; random stalls on both sides.
`default_nettype none

module fast_exp_quadratic_float_core_tb import fexp_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 1600;
    localparam int LATENCY    = 31;
    localparam int HOLD_LEN   = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_x_bits;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_y_bits;

    // Expected exponentials, oldest first.
    logic [31:0] exp_queue[$];
    int          n_errors;
    int          n_requests;
    int          n_results;
    int          n_special;
    bit          stim_done;

    fast_exp_quadratic_float_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_x_bits (i_x_bits),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_y_bits (o_y_bits)
    );

    // Clock with a 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Number of significant bits in a 64-bit word.
    function automatic int msb_count(input logic [63:0] m);
        int n;
        n = 0;
        for (int k = 0; k < 64; k++) begin
            if (m[k]) begin
                n = k + 1;
            end
        end
        return n;
    endfunction

    // Split a single-precision pattern into sign, significand and scale.
    function automatic void split_float(input logic [31:0] b, output logic [31:0] s,
                                        output logic [63:0] m, output int e);
        s = b & K_SIGN;
        if (b[30:23] == 8'd0) begin
            m = {41'd0, b[22:0]};
            e = -149;
        end else begin
            m = {40'd0, 1'b1, b[22:0]};
            e = int'(b[30:23]) - 150;
        end
    endfunction

    // Round sign * m * 2^e to single precision, nearest even.
    function automatic logic [31:0] round_float(input logic [31:0] sign, input logic [63:0] m,
                                                input int e);
        int          sh;
        int          e2;
        int          biased;
        logic [63:0] q;
        bit          half;
        bit          rest;
        if (m == 64'd0) begin
            return sign;
        end
        sh = msb_count(m) - 24;
        e2 = e + sh;
        if (e2 < -149) begin
            sh += -149 - e2;
            e2 = -149;
        end
        half = 1'b0;
        rest = 1'b0;
        if (sh <= 0) begin
            q = m << (-sh);
        end else begin
            if (sh < 64) begin
                q = m >> sh;
                half = m[sh-1];
                rest = (m & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
            end else if (sh == 64) begin
                q = 64'd0;
                half = m[63];
                rest = m[62:0] != 63'd0;
            end else begin
                q = 64'd0;
            end
            if (half && (rest || q[0])) begin
                q++;
                if (q == (64'd1 << 24)) begin
                    q >>= 1;
                    e2++;
                end
            end
        end
        if (q >= (64'd1 << 23)) begin
            biased = e2 + 150;
            if (biased >= 255) begin
                return sign | 32'h7F800000;
            end
            return sign | (32'(biased) << 23) | {9'd0, q[22:0]};
        end
        return sign | q[31:0];
    endfunction

    // Fused multiply-add a*b + c on finite operands with a single rounding.
    function automatic logic [31:0] fma_single(input logic [31:0] a, input logic [31:0] b,
                                               input logic [31:0] c);
        logic [31:0] sa, sb, sc, sp, sbig, ssml, sign;
        logic [63:0] ma, mb, mc, mp, big, sml, m;
        int          ea, eb, ec, ep, ebig, d, l;
        split_float(a, sa, ma, ea);
        split_float(b, sb, mb, eb);
        split_float(c, sc, mc, ec);
        sp = sa ^ sb;
        mp = ma * mb;
        ep = ea + eb;
        if (mp == 64'd0 && mc == 64'd0) begin
            return (sp == sc) ? sp : 32'd0;
        end
        if (mp == 64'd0) begin
            return c;
        end
        if (mc == 64'd0) begin
            return round_float(sp, mp, ep);
        end
        l = msb_count(mp);
        mp <<= (62 - l);
        ep -= 62 - l;
        l = msb_count(mc);
        mc <<= (62 - l);
        ec -= 62 - l;
        if (ep >= ec) begin
            big = mp; sbig = sp; ebig = ep; sml = mc; ssml = sc; d = ep - ec;
        end else begin
            big = mc; sbig = sc; ebig = ec; sml = mp; ssml = sp; d = ec - ep;
        end
        if (d >= 63) begin
            sml = 64'd1;
        end else if (d > 0) begin
            sml = (sml >> d) | 64'((sml & ((64'd1 << d) - 64'd1)) != 64'd0);
        end
        if (sbig == ssml) begin
            m = big + sml;
            sign = sbig;
        end else if (big >= sml) begin
            m = big - sml;
            sign = sbig;
        end else begin
            m = sml - big;
            sign = ssml;
        end
        if (m == 64'd0) begin
            return 32'd0;
        end
        return round_float(sign, m, ebig);
    endfunction

    // Float to int32 with nearest-even rounding; out of range gives the sign-bit pattern.
    function automatic logic [31:0] float_to_int(input logic [31:0] t);
        logic [31:0] sig, v, q, rest;
        int          bexp, sh;
        bexp = int'(t[30:23]);
        sig = {9'd1, t[22:0]};
        if (bexp >= 158) begin
            return K_SIGN;
        end
        if (bexp < 126) begin
            return 32'd0;
        end
        if (bexp >= 150) begin
            v = sig << (bexp - 150);
        end else begin
            sh = 150 - bexp;
            q = sig >> sh;
            rest = sig & ((32'd1 << (sh - 1)) - 32'd1);
            if (sig[sh-1] && (rest != 32'd0 || q[0])) begin
                q++;
            end
            v = q;
        end
        if (t[31]) begin
            v = 32'd0 - v;
        end
        return v;
    endfunction

    // Predicted exponential pattern for one argument.
    function automatic logic [31:0] predict_exp(input logic [31:0] x);
        logic [31:0] t, a, r, f, p, n;
        if (x[30:23] == 8'hFF) begin
            return (x[22:0] != 23'd0) ? (x | 32'h00400000) : K_DNAN;
        end
        t = fma_single(x, K_L2E, K_SIGN);
        if (t[30:0] == 31'h7F800000) begin
            return K_DNAN;
        end
        a = fma_single(t, K_ONE, K_CVT);
        r = fma_single(a, K_ONE, K_CVT ^ K_SIGN);
        f = fma_single(t, K_ONE, r ^ K_SIGN);
        p = fma_single(K_C0, f, K_C1);
        p = fma_single(p, f, K_C2);
        n = float_to_int(t);
        return (n << 23) + p;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        $display("MISMATCH %s at %0t: got %08h expected %08h", what, $realtime, got, want);
    endtask

    // Directed arguments; expected value given where it follows directly, else checked
    // against the predictor.
    typedef struct {
        logic [31:0] x;
        bit          known;
        logic [31:0] y;
    } t_dir_row;

    t_dir_row dir_table[] = '{
        '{32'h00000000, 1'b0, 32'h0},  // zero
        '{32'h80000000, 1'b0, 32'h0},  // negative zero
        '{32'h3F800000, 1'b0, 32'h0},  // one
        '{32'hBF800000, 1'b0, 32'h0},  // minus one
        '{32'h00000001, 1'b0, 32'h0},  // smallest subnormal
        '{32'h807FFFFF, 1'b0, 32'h0},  // largest negative subnormal
        '{32'h00800000, 1'b0, 32'h0},  // smallest normal
        '{32'h7F800000, 1'b1, 32'hFFC00000},  // plus infinity
        '{32'hFF800000, 1'b1, 32'hFFC00000},  // minus infinity
        '{32'h7FC00000, 1'b1, 32'h7FC00000},  // quiet NaN
        '{32'h7F800001, 1'b1, 32'h7FC00001},  // signaling NaN gets quieted
        '{32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},  // all-ones NaN
        '{32'h7F7FFFFF, 1'b1, 32'hFFC00000},  // largest finite: product overflows
        '{32'hFF7FFFFF, 1'b1, 32'hFFC00000},  // most negative finite: product overflows
        '{32'h7F000000, 1'b0, 32'h0},  // product stays finite, conversion out of range
        '{32'h4EFFFFFF, 1'b0, 32'h0},  // x just below 2^31; t beyond the int32 range
        '{32'h42B17218, 1'b0, 32'h0},  // near ln of max float
        '{32'hC2CE8ED0, 1'b0, 32'h0},  // near underflow
        '{32'h42FE0000, 1'b0, 32'h0},  // wraps through exponent field
        '{32'h3F000000, 1'b0, 32'h0},  // one half
        '{32'h3F317218, 1'b0, 32'h0},  // ln 2: t near one
        '{32'hBF317218, 1'b0, 32'h0},  // minus ln 2
        '{32'h4B400000, 1'b0, 32'h0}   // rounding constant itself
    };

    // Pick a random argument, mostly in the useful range with some raw patterns.
    function automatic logic [31:0] random_arg();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            return {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 133)), 23'($urandom)};
        end else if (sel < 7) begin
            return {$urandom_range(0, 1) == 1, 8'($urandom_range(0, 1)), 23'($urandom)};
        end else if (sel < 8) begin
            return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(0, 3) == 0 ? 0 : $urandom)};
        end
        return $urandom;
    endfunction

    // Random gap length: mostly short, a few long.
    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 10) begin
            return 0;
        end else if (sel < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Offer one request and wait until it is taken.
    task automatic send_arg(input logic [31:0] x);
        i_valid  <= 1'b1;
        i_x_bits <= x;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        exp_queue.push_back(predict_exp(x));
        n_requests++;
        if (x[30:23] == 8'hFF) begin
            n_special++;
        end
        @(negedge i_clk);
    endtask

    task automatic idle_input(input int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Sender process: directed table, then random arguments.
    initial begin
        n_errors    = 0;
        n_requests  = 0;
        n_results   = 0;
        n_special   = 0;
        stim_done   = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_x_bits    = 32'd0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (dir_table[k]) begin
            if (dir_table[k].known && predict_exp(dir_table[k].x) != dir_table[k].y) begin
                report_mismatch("predictor vs table", predict_exp(dir_table[k].x),
                                dir_table[k].y);
            end
            send_arg(dir_table[k].x);
            idle_input(gap_len());
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            send_arg(random_arg());
            if (k > 200 && k < 500) begin
                idle_input(0);
            end else begin
                idle_input(gap_len());
            end
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off to fill the pipeline.
    initial begin
        int cnt;
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        while (n_requests < 250) begin
            @(negedge i_clk);
            i_ready <= ($urandom_range(0, 3) != 0);
        end
        @(negedge i_clk);
        i_ready <= 1'b0;
        cnt = 0;
        while (cnt < HOLD_LEN) begin
            @(negedge i_clk);
            cnt++;
        end
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                stall = gap_len();
                if (stall > 0) begin
                    i_ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            i_ready <= 1'b1;
        end
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_queue.size() == 0) begin
                report_mismatch("unexpected result", o_y_bits, 32'd0);
            end else begin
                logic [31:0] want;
                want = exp_queue.pop_front();
                if (o_y_bits !== want) begin
                    report_mismatch("y_bits", o_y_bits, want);
                end
                n_results++;
            end
        end
    end

    // End of run once stimulus is done and nothing is outstanding.
    initial begin
        wait (stim_done);
        while (exp_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (exp_queue.size() != 0) begin
            n_errors += exp_queue.size();
        end
        $display("Run covered %0d requests (%0d infinite or NaN) and %0d checked results,",
                 n_requests, n_special, n_results);
        $display("including a %0d-cycle output hold-off with the input kept busy.", HOLD_LEN);
        if (n_errors == 0) begin
            $display("** fast_exp_quadratic_float_core: PASSED **");
        end else begin
            $display("** fast_exp_quadratic_float_core: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #10ms;
        $display("Timeout with %0d results outstanding.", exp_queue.size());
        $display("** fast_exp_quadratic_float_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
